### hdl/astar_pkg.sv
// shared constants and types for the a-star path search block
// no dependencies; imported by the top level and the checker of the block
package astar_pkg;

    localparam int NUM_VERTICES_DEF = 32;
    localparam int WEIGHT_W         = 16;
    localparam int COST_W           = 22;
    localparam int VERTEX_W         = 5;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_EDGE   = 2'd1,
        OP_HEUR   = 2'd2,
        OP_SEARCH = 2'd3
    } op_t;

    typedef enum logic [12:0] {
        ST_CLR        = 13'b0000000000001,
        ST_IDLE       = 13'b0000000000010,
        ST_EXP        = 13'b0000000000100,
        ST_EXP_END    = 13'b0000000001000,
        ST_SEL        = 13'b0000000010000,
        ST_SEL_END    = 13'b0000000100000,
        ST_DECIDE     = 13'b0000001000000,
        ST_POP        = 13'b0000010000000,
        ST_BT         = 13'b0000100000000,
        ST_BT_WAIT    = 13'b0001000000000,
        ST_EMIT_START = 13'b0010000000000,
        ST_EMIT_RD    = 13'b0100000000000,
        ST_NOPATH     = 13'b1000000000000
    } state_t;

endpackage

### hdl/astar_ram.sv
// generic single-write single-read ram with registered read data
// depends on nothing
module astar_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/astar_path_search_top.sv
// a-star shortest path search: graph, heuristic, node and path rams plus sequencer
// depends on astar_pkg and astar_ram
//
//  channel | signals                            | direction
//  req     | req_valid/req_ready, op, vertex_a, | in
//          | vertex_b, value                    |
//  rsp     | rsp_valid/rsp_ready, path_vertex,  | out
//          | found, last                        |
//
// loads are written in their transfer. a search runs expansions, each one neighbour scan
// and one open-list scan through the rams, one entry a cycle, then a select and a pop;
// up to N+1 expansions, then a backtrack through the node ram per path vertex, the start
// result and the path vertices read back from the stack ram for emit.
// after reset and after a clear transfer the edge and heuristic rams are swept
// with req_ready low. rsp stalls hold the sequencer at the emit and no-path steps.
module astar_path_search_top #(
    parameter int NUM_VERTICES = astar_pkg::NUM_VERTICES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic [1:0]                     op,
    input  logic [astar_pkg::VERTEX_W-1:0] vertex_a,
    input  logic [astar_pkg::VERTEX_W-1:0] vertex_b,
    input  logic [astar_pkg::WEIGHT_W-1:0] value,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output logic [astar_pkg::VERTEX_W-1:0] path_vertex,
    output logic                           found,
    output logic                           last
);
    import astar_pkg::*;

    localparam int N     = NUM_VERTICES;
    localparam int VW    = $clog2(N);
    localparam int EDEP  = N * N;
    localparam int EAW   = $clog2(EDEP);
    localparam int DW    = $clog2(N + 1);
    localparam int PW    = $clog2(N + 2);
    localparam int NODEW = COST_W + VW;

    state_t state_reg, state_next;
    logic [VW-1:0]       cur_reg, cur_next, start_reg, start_next, goal_reg, goal_next;
    logic [VW-1:0]       idx_reg, idx_next, pidx_reg, pidx_next;
    logic [VW-1:0]       best_reg, best_next, u_reg, u_next;
    logic [COST_W-1:0]   g_reg, g_next, bcost_reg, bcost_next;
    logic                pexp_reg, pexp_next, psel_reg, psel_next, bval_reg, bval_next;
    logic [PW-1:0]       pops_reg, pops_next;
    logic [DW-1:0]       depth_reg, depth_next, k_reg, k_next;
    logic [EAW-1:0]      clr_reg, clr_next;
    logic [N-1:0]        seen_reg, seen_next, open_reg, open_next, pval_reg, pval_next;
    logic                rsp_valid_reg, rsp_valid_next, found_reg, found_next;
    logic                last_reg, last_next;
    logic [VERTEX_W-1:0] path_reg, path_next;

    logic                e_we;
    logic [EAW-1:0]      e_waddr, e_raddr;
    logic [WEIGHT_W-1:0] e_wdata, e_rdata;
    logic                h_we;
    logic [VW-1:0]       h_waddr, h_raddr;
    logic [WEIGHT_W-1:0] h_wdata, h_rdata;
    logic                n_we;
    logic [VW-1:0]       n_waddr, n_raddr;
    logic [NODEW-1:0]    n_wdata, n_rdata;
    logic                s_we;
    logic [VW-1:0]       s_waddr, s_raddr, s_rdata;

    logic                a_ok, b_ok, out_free;
    logic [VW-1:0]       a_v, b_v;
    logic [COST_W-1:0]   n_cost;
    logic [DW-1:0]       k_dec;
    op_t                 op_c;

    localparam logic [EAW-1:0] NA = EAW'(N);

    assign op_c     = op_t'(op);
    assign a_ok     = 7'(vertex_a) < 7'(N);
    assign b_ok     = 7'(vertex_b) < 7'(N);
    assign a_v      = VW'(vertex_a);
    assign b_v      = VW'(vertex_b);
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign n_cost   = n_rdata[NODEW-1:VW];
    assign k_dec    = k_reg - DW'(1);
    assign s_raddr  = k_dec[VW-1:0];

    assign req_ready   = (state_reg == ST_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign path_vertex = path_reg;
    assign found       = found_reg;
    assign last        = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        start_next     = start_reg;
        goal_next      = goal_reg;
        idx_next       = idx_reg;
        pidx_next      = pidx_reg;
        best_next      = best_reg;
        u_next         = u_reg;
        g_next         = g_reg;
        bcost_next     = bcost_reg;
        pexp_next      = 1'b0;
        psel_next      = 1'b0;
        bval_next      = bval_reg;
        pops_next      = pops_reg;
        depth_next     = depth_reg;
        k_next         = k_reg;
        clr_next       = clr_reg;
        seen_next      = seen_reg;
        open_next      = open_reg;
        pval_next      = pval_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        found_next     = found_reg;
        last_next      = last_reg;
        path_next      = path_reg;

        e_we    = 1'b0;
        e_waddr = EAW'(a_v) * NA + EAW'(b_v);
        e_wdata = value;
        e_raddr = EAW'(cur_reg) * NA + EAW'(idx_reg);
        h_we    = 1'b0;
        h_waddr = a_v;
        h_wdata = value;
        h_raddr = idx_reg;
        n_we    = 1'b0;
        n_waddr = pidx_reg;
        n_wdata = {g_reg + COST_W'(e_rdata) + COST_W'(h_rdata), cur_reg};
        n_raddr = idx_reg;
        s_we    = 1'b0;
        s_waddr = depth_reg[VW-1:0];

        // neighbour data returns in the cycle after its read
        if (pexp_reg && e_rdata != '0 && !seen_reg[pidx_reg])
        begin
            seen_next[pidx_reg] = 1'b1;
            open_next[pidx_reg] = 1'b1;
            pval_next[pidx_reg] = (pops_reg != '0);
            n_we = 1'b1;
        end
        // open-list compare, strict less keeps the lowest index on ties
        if (psel_reg && open_reg[pidx_reg] && (!bval_reg || n_cost < bcost_reg))
        begin
            bval_next  = 1'b1;
            bcost_next = n_cost;
            best_next  = pidx_reg;
        end

        case (state_reg)
            ST_CLR:
            begin
                e_we    = 1'b1;
                e_waddr = clr_reg;
                e_wdata = '0;
                h_we    = (clr_reg < NA);
                h_waddr = clr_reg[VW-1:0];
                h_wdata = '0;
                if (clr_reg == EAW'(EDEP - 1))
                begin
                    clr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + EAW'(1);
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (op_c)
                        OP_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = ST_CLR;
                        end
                        OP_EDGE:
                        begin
                            e_we = a_ok && b_ok;
                        end
                        OP_HEUR:
                        begin
                            h_we = a_ok;
                        end
                        OP_SEARCH:
                        begin
                            if (a_ok && b_ok)
                            begin
                                start_next = a_v;
                                goal_next  = b_v;
                                cur_next   = a_v;
                                g_next     = '0;
                                seen_next  = '0;
                                open_next  = '0;
                                pval_next  = '0;
                                pops_next  = '0;
                                idx_next   = '0;
                                state_next = ST_EXP;
                            end
                            else
                            begin
                                state_next = ST_NOPATH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EXP:
            begin
                pexp_next = 1'b1;
                pidx_next = idx_reg;
                if (idx_reg == VW'(N - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_EXP_END;
                end
                else
                begin
                    idx_next = idx_reg + VW'(1);
                end
            end
            ST_EXP_END:
            begin
                bval_next  = 1'b0;
                state_next = ST_SEL;
            end
            ST_SEL:
            begin
                psel_next = 1'b1;
                pidx_next = idx_reg;
                if (idx_reg == VW'(N - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_SEL_END;
                end
                else
                begin
                    idx_next = idx_reg + VW'(1);
                end
            end
            ST_SEL_END:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                h_raddr = best_reg;
                if (!bval_reg)
                begin
                    state_next = ST_NOPATH;
                end
                else
                begin
                    open_next[best_reg] = 1'b0;
                    cur_next            = best_reg;
                    state_next          = ST_POP;
                end
            end
            ST_POP:
            begin
                g_next    = bcost_reg - COST_W'(h_rdata);
                pops_next = pops_reg + PW'(1);
                if (best_reg == goal_reg)
                begin
                    u_next     = best_reg;
                    depth_next = '0;
                    state_next = ST_BT;
                end
                else if (pops_reg == PW'(N))
                begin
                    state_next = ST_NOPATH;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_EXP;
                end
            end
            ST_BT:
            begin
                n_raddr = u_reg;
                if (depth_reg == DW'(N))
                begin
                    state_next = ST_EMIT_START;
                end
                else
                begin
                    s_we       = 1'b1;
                    depth_next = depth_reg + DW'(1);
                    state_next = pval_reg[u_reg] ? ST_BT_WAIT : ST_EMIT_START;
                end
            end
            ST_BT_WAIT:
            begin
                u_next     = n_rdata[VW-1:0];
                state_next = ST_BT;
            end
            ST_EMIT_START:
            begin
                k_next = depth_reg;
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    path_next      = VERTEX_W'(start_reg);
                    found_next     = 1'b1;
                    last_next      = 1'b0;
                    state_next     = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                // stack read address follows k, data is valid here
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    path_next      = VERTEX_W'(s_rdata);
                    found_next     = 1'b1;
                    last_next      = (k_reg == DW'(1));
                    k_next         = k_dec;
                    state_next     = (k_reg == DW'(1)) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_NOPATH:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    path_next      = '0;
                    found_next     = 1'b0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a fresh stack address is held while the registered stack ram read returns its data
    logic emit_hold_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_hold_reg <= 1'b0;
        end
        else
        begin
            emit_hold_reg <= !emit_hold_reg && (state_next == ST_EMIT_RD)
                             && (k_next != k_reg || state_reg != ST_EMIT_RD);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_reg       <= '0;
            cur_reg       <= '0;
            g_reg         <= '0;
            pexp_reg      <= 1'b0;
            psel_reg      <= 1'b0;
            bval_reg      <= 1'b0;
            pops_reg      <= '0;
            depth_reg     <= '0;
            k_reg         <= '0;
            seen_reg      <= '0;
            open_reg      <= '0;
            pval_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_EMIT_RD && emit_hold_reg)
        begin
            // wait for registered stack data, output side keeps draining
            rsp_valid_reg <= rsp_valid_reg && !rsp_ready;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cur_reg       <= cur_next;
            g_reg         <= g_next;
            pexp_reg      <= pexp_next;
            psel_reg      <= psel_next;
            bval_reg      <= bval_next;
            pops_reg      <= pops_next;
            depth_reg     <= depth_next;
            k_reg         <= k_next;
            seen_reg      <= seen_next;
            open_reg      <= open_next;
            pval_reg      <= pval_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!(state_reg == ST_EMIT_RD && emit_hold_reg))
        begin
            start_reg <= start_next;
            goal_reg  <= goal_next;
            idx_reg   <= idx_next;
            pidx_reg  <= pidx_next;
            best_reg  <= best_next;
            u_reg     <= u_next;
            bcost_reg <= bcost_next;
            found_reg <= found_next;
            last_reg  <= last_next;
            path_reg  <= path_next;
        end
    end

    // edge writes only in the sweep or on an edge load transfer
    astar_ram #(.WIDTH(WEIGHT_W), .DEPTH(EDEP)) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    astar_ram #(.WIDTH(WEIGHT_W), .DEPTH(N)) u_heur_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    astar_ram #(.WIDTH(NODEW), .DEPTH(N)) u_node_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (n_raddr),
        .rdata (n_rdata)
    );

    astar_ram #(.WIDTH(VW), .DEPTH(N)) u_stack_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (u_reg),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

endmodule

### hdl/astar_chk.sv
// port-level checks for the a-star path search block, bound to the top level
// depends on astar_pkg and astar_path_search_top
module astar_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic [1:0]                     op,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [astar_pkg::VERTEX_W-1:0] path_vertex,
    input logic                           found,
    input logic                           last
);
    import astar_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(path_vertex)
            && $stable(found) && $stable(last))
        else $error("rsp payload changed while stalled");

    a_nopath_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !found |-> last && path_vertex == '0)
        else $error("no-path result not final or not zero");

    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && op == OP_SEARCH |=> !req_ready)
        else $error("search transfer did not occupy the block");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && op == OP_CLEAR |=> !req_ready)
        else $error("clear transfer did not start the sweep");

endmodule

bind astar_path_search_top astar_chk u_astar_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .op          (op),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .path_vertex (path_vertex),
    .found       (found),
    .last        (last)
);
